// File: hw/rtl/awrm_pkg.sv
// ----------------------------------------------------------------------------
// awrm_pkg: shared types and constants of the area-weighted region mean
// Widths of coordinates, weights, accumulators and register indexes.
// ----------------------------------------------------------------------------
package awrm_pkg;

	localparam int MAX_DIM  = 2048;
	localparam int COORD_F  = 8;
	localparam int CH_W     = 25;
	localparam int DIM_W    = 12;
	localparam int POS_W    = 11;
	localparam int COORD_W  = 22;
	localparam int CW       = COORD_W + 1;
	localparam int DXY_W    = COORD_F + 1;
	localparam int WGT_W    = 2 * COORD_F + 1;
	localparam int PROD_W   = CH_W + WGT_W + 1;
	localparam int SUM_W    = 64;
	localparam int AREA_W   = 40;
	localparam int TALLY_W  = 23;
	localparam int LANES    = 4;
	localparam int CNT_W    = 6;
	localparam int ADDR_W   = 5;

	typedef enum logic [2:0] {
		REG_IMG_WIDTH  = 3'd0,
		REG_IMG_HEIGHT = 3'd1,
		REG_RECT_MIN_X = 3'd2,
		REG_RECT_MIN_Y = 3'd3,
		REG_RECT_MAX_X = 3'd4,
		REG_RECT_MAX_Y = 3'd5
	} reg_idx_t;

	// Per-pixel control and weight leaving the coordinate stage
	typedef struct packed {
		logic             valid;
		logic             start;
		logic             last;
		logic             clip;
		logic [WGT_W-1:0] weight;
	} wgt_ctrl_t;

endpackage

// File: hw/rtl/awrm_weight.sv
// ----------------------------------------------------------------------------
// awrm_weight: raster position and overlap weight
// Tracks the pixel position, clips the rectangle to the image and registers
// the overlap area of each accepted pixel with the clipped rectangle.
// ----------------------------------------------------------------------------
module awrm_weight (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               frame_start,
	input  logic [awrm_pkg::DIM_W-1:0]         img_width,
	input  logic [awrm_pkg::DIM_W-1:0]         img_height,
	input  logic signed [awrm_pkg::COORD_W-1:0] rect_min_x,
	input  logic signed [awrm_pkg::COORD_W-1:0] rect_min_y,
	input  logic signed [awrm_pkg::COORD_W-1:0] rect_max_x,
	input  logic signed [awrm_pkg::COORD_W-1:0] rect_max_y,
	output awrm_pkg::wgt_ctrl_t                ctrl_s1
);
	import awrm_pkg::*;

	logic [POS_W-1:0]    col_q, row_q, cx, ry;
	logic [DIM_W-1:0]    w_eff, h_eff;
	logic signed [CW-1:0] x0, y0, x1, y1, x_lim, y_lim;
	logic signed [CW-1:0] x_lo, x_hi, y_lo, y_hi, dx, dy;
	logic [DXY_W-1:0]    dx_c, dy_c;
	logic [2*DXY_W-1:0]  area;
	logic                clip, col_end, row_end;

	// Clamp the image size to the supported range
	always_comb begin
		if (img_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (img_width > DIM_W'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = img_width;
		end
		if (img_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (img_height > DIM_W'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = img_height;
		end
	end

	// Clip the rectangle to the image
	always_comb begin
		x_lim = CW'({w_eff, COORD_F'(0)});
		y_lim = CW'({h_eff, COORD_F'(0)});
		x0 = (rect_min_x < 0) ? CW'(0) : CW'(rect_min_x);
		y0 = (rect_min_y < 0) ? CW'(0) : CW'(rect_min_y);
		x1 = (CW'(rect_max_x) < x_lim) ? CW'(rect_max_x) : x_lim;
		y1 = (CW'(rect_max_y) < y_lim) ? CW'(rect_max_y) : y_lim;
		clip = (x1 > x0) && (y1 > y0);
	end

	// Overlap of the current pixel with the clipped rectangle
	always_comb begin
		cx = frame_start ? '0 : col_q;
		ry = frame_start ? '0 : row_q;
		x_lo = CW'({cx, COORD_F'(0)});
		x_hi = CW'({{1'b0, cx} + (POS_W+1)'(1), COORD_F'(0)});
		y_lo = CW'({ry, COORD_F'(0)});
		y_hi = CW'({{1'b0, ry} + (POS_W+1)'(1), COORD_F'(0)});
		dx = ((x_hi < x1) ? x_hi : x1) - ((x_lo > x0) ? x_lo : x0);
		dy = ((y_hi < y1) ? y_hi : y1) - ((y_lo > y0) ? y_lo : y0);
		dx_c = (dx > 0) ? dx[DXY_W-1:0] : '0;
		dy_c = (dy > 0) ? dy[DXY_W-1:0] : '0;
		area = (2*DXY_W)'(dx_c) * (2*DXY_W)'(dy_c);
		col_end = {1'b0, cx} >= (w_eff - DIM_W'(1));
		row_end = {1'b0, ry} >= (h_eff - DIM_W'(1));
	end

	// Advance the raster position and register the weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= accept;
			if (accept) begin
				if (col_end && row_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_end) begin
					col_q <= '0;
					row_q <= ry + POS_W'(1);
				end else begin
					col_q <= cx + POS_W'(1);
					row_q <= ry;
				end
				ctrl_s1.start  <= frame_start;
				ctrl_s1.last   <= col_end && row_end;
				ctrl_s1.clip   <= clip;
				ctrl_s1.weight <= clip ? area[WGT_W-1:0] : '0;
			end
		end
	end

endmodule

// File: hw/rtl/awrm_lane.sv
// ----------------------------------------------------------------------------
// awrm_lane: one colour channel
// Weights the channel value, accumulates the frame sum and divides it by
// the frame area one quotient bit per cycle, with saturation to 25 bits.
// ----------------------------------------------------------------------------
module awrm_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  awrm_pkg::wgt_ctrl_t               ctrl_s1,
	input  logic signed [awrm_pkg::CH_W-1:0]  pix_s1,
	input  logic                              acc_en,
	input  logic                              start_s2,
	input  logic                              div_start,
	input  logic                              step,
	input  logic [awrm_pkg::AREA_W-1:0]       divisor,
	output logic signed [awrm_pkg::CH_W-1:0]  mean
);
	import awrm_pkg::*;

	logic signed [PROD_W-1:0] prod_s2, mul_a, mul_b;
	logic [SUM_W-1:0]         sum_q, sum_next;
	logic [SUM_W-1:0]         quo_q;
	logic [AREA_W-1:0]        rem_q;
	logic [AREA_W:0]          trial;
	logic                     neg_q;

	assign mul_a = PROD_W'(pix_s1);
	assign mul_b = PROD_W'({1'b0, ctrl_s1.weight});

	// Weight the channel value
	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
	end

	assign sum_next = (start_s2 ? '0 : sum_q) + SUM_W'(prod_s2);

	// Accumulate; drop the sum into the divider at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (acc_en) begin
			sum_q <= div_start ? '0 : sum_next;
		end
	end

	assign trial = {rem_q, quo_q[SUM_W-1]};

	// Restoring division of the magnitude, one bit per cycle
	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= sum_next[SUM_W-1];
			quo_q <= sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
			rem_q <= '0;
		end else if (step) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= AREA_W'(trial - {1'b0, divisor});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[AREA_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	// Apply the sign and saturate
	always_comb begin
		if (neg_q) begin
			if (quo_q > SUM_W'(1) << (CH_W-1)) begin
				mean = {1'b1, {(CH_W-1){1'b0}}};
			end else begin
				mean = -$signed(quo_q[CH_W-1:0]);
			end
		end else begin
			if (quo_q > (SUM_W'(1) << (CH_W-1)) - SUM_W'(1)) begin
				mean = {1'b0, {(CH_W-1){1'b1}}};
			end else begin
				mean = $signed(quo_q[CH_W-1:0]);
			end
		end
	end

endmodule

// File: hw/rtl/area_weighted_region_mean.sv
// ----------------------------------------------------------------------------
// area_weighted_region_mean: box-filter mean of RGBA pixels over a rectangle
// Four channel lanes weight and accumulate each pixel; at frame end the
// lanes divide by the covered area and the result is merged into one item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: r,g,b,a; tuser: frame_start
//  m_*       out  m_tvalid/m_tready  tdata: means r,g,b,a, count; tuser: found
//  apb       in   psel/penable/...   six configuration registers, 4-byte spaced
//
//  Pixels are taken one per cycle while s_tready is high; a pixel reaches
//  the accumulators through the s1 and s2 pipeline registers.
//  The frame-end pixel starts a division in the lanes; s_tready is low from
//  its acceptance until the result is loaded into the output register.
//  A result still waiting in the output register holds the next frame-end
//  result in the lanes, and s_tready low with it; other pixels are not held.
//  Reset clears position, accumulators and registers to their defaults.
// ----------------------------------------------------------------------------
module area_weighted_region_mean (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [103:0]                  s_tdata,  // r[24:0] g[49:25] b[74:50] a[99:75]
	input  logic                          s_tuser,  // frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [127:0]                  m_tdata,  // r, g, b, a means, covered_count[122:100]
	output logic                          m_tuser,  // found
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [awrm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import awrm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIM_W-1:0]        width_q, height_q;
	logic signed [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic                    accept, cfg_wr, div_start, step, out_load;
	reg_idx_t                widx;
	wgt_ctrl_t               ctrl_s1, ctrl_s2;
	logic signed [CH_W-1:0]  pix_s1 [LANES];
	logic signed [CH_W-1:0]  mean [LANES];
	logic [AREA_W-1:0]       area_q, area_next, area_div_q;
	logic [TALLY_W-1:0]      tally_q, tally_next, count_q;
	logic                    found_q;
	logic                    m_tvalid_q, m_tuser_q;
	logic [127:0]            m_tdata_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			min_x_q  <= '0;
			min_y_q  <= '0;
			max_x_q  <= '0;
			max_y_q  <= '0;
		end else if (cfg_wr) begin
			case (widx)
				REG_IMG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_IMG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_RECT_MIN_X: min_x_q  <= pwdata[COORD_W-1:0];
				REG_RECT_MIN_Y: min_y_q  <= pwdata[COORD_W-1:0];
				REG_RECT_MAX_X: max_x_q  <= pwdata[COORD_W-1:0];
				REG_RECT_MAX_Y: max_y_q  <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_IMG_WIDTH:  prdata = 32'(width_q);
			REG_IMG_HEIGHT: prdata = 32'(height_q);
			REG_RECT_MIN_X: prdata = 32'(unsigned'(min_x_q));
			REG_RECT_MIN_Y: prdata = 32'(unsigned'(min_y_q));
			REG_RECT_MAX_X: prdata = 32'(unsigned'(max_x_q));
			REG_RECT_MAX_Y: prdata = 32'(unsigned'(max_y_q));
			default:        prdata = '0;
		endcase
	end

	// Hold input while a frame end is in flight, dividing or waiting for the output register
	assign s_tready = (state_q == ST_IDLE) && !(ctrl_s1.valid && ctrl_s1.last)
		&& !(ctrl_s2.valid && ctrl_s2.last);
	assign accept = s_tvalid && s_tready;

	awrm_weight u_weight (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (s_tuser),
		.img_width   (width_q),
		.img_height  (height_q),
		.rect_min_x  (min_x_q),
		.rect_min_y  (min_y_q),
		.rect_max_x  (max_x_q),
		.rect_max_y  (max_y_q),
		.ctrl_s1     (ctrl_s1)
	);

	// Channel values alongside the weight
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LANES; i++) begin
				pix_s1[i] <= s_tdata[i*CH_W +: CH_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	assign div_start = ctrl_s2.valid && ctrl_s2.last;
	assign step      = (state_q == ST_DIV);

	generate
		for (genvar g = 0; g < LANES; g++) begin : g_lane
			awrm_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl_s1   (ctrl_s1),
				.pix_s1    (pix_s1[g]),
				.acc_en    (ctrl_s2.valid),
				.start_s2  (ctrl_s2.start),
				.div_start (div_start),
				.step      (step),
				.divisor   (area_div_q),
				.mean      (mean[g])
			);
		end
	endgenerate

	// Area and covered-pixel accumulators
	assign area_next  = (ctrl_s2.start ? '0 : area_q) + AREA_W'(ctrl_s2.weight);
	assign tally_next = (ctrl_s2.start ? '0 : tally_q)
		+ TALLY_W'(ctrl_s2.weight != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q  <= '0;
			tally_q <= '0;
		end else if (ctrl_s2.valid) begin
			area_q  <= ctrl_s2.last ? '0 : area_next;
			tally_q <= ctrl_s2.last ? '0 : tally_next;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			area_div_q <= area_next;
			found_q    <= ctrl_s2.clip && (area_next != '0);
			count_q    <= tally_next;
		end
	end

	// Sequence the division and merge the lanes into the result
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q    <= ST_IDLE;
						m_tuser_q  <= found_q;
						for (int i = 0; i < LANES; i++) begin
							m_tdata_q[i*CH_W +: CH_W] <= found_q ? mean[i] : '0;
						end
						m_tdata_q[LANES*CH_W +: TALLY_W] <= count_q;
						m_tdata_q[127:LANES*CH_W+TALLY_W] <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("pixel accepted during division");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == ST_IDLE))
		else $error("division started while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten");
	a_found_area: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && found_q) |-> (area_div_q != '0))
		else $error("found with empty area");
`endif

endmodule

// File: dv/tb_area_weighted_region_mean.sv
// ----------------------------------------------------------------------------
// tb_area_weighted_region_mean: self-checking bench of the region mean block
// Streams RGBA frames through the block under several image sizes and clip
// rectangles, predicts each frame result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_area_weighted_region_mean;
	import awrm_pkg::*;

	typedef struct {
		logic               start;
		logic signed [24:0] ch [4];
	} pixel_t;

	typedef struct {
		logic        found;
		logic [24:0] mean [4];
		logic [22:0] count;
	} frame_mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic m_tuser;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	area_weighted_region_mean DUT (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [11:0] cfg_w = 12'd1, cfg_h = 12'd1;
	logic signed [21:0] r_x0 = '0, r_y0 = '0, r_x1 = '0, r_y1 = '0;
	int unsigned col = 0, row = 0;
	logic [63:0] sums [4];
	logic [39:0] area_acc = '0;
	logic [22:0] tally = '0;

	pixel_t pending_pixels [$];
	frame_mean_t expected_means [$];
	int errors = 0;
	int idle_pct = 19;
	int hold_off = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	bit sender_pause = 1'b0;
	int quiet = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic longint eff_dim(input logic [11:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic logic [24:0] divide_mean(input logic [63:0] s, input logic [39:0] a);
		logic [63:0] mag;
		logic [63:0] q;
		mag = s[63] ? (~s + 64'd1) : s;
		q = mag / {24'd0, a};
		if (s[63]) begin
			if (q > 64'd16777216) return 25'h1000000;
			return 25'(-q);
		end
		if (q > 64'd16777215) return 25'h0FFFFFF;
		return q[24:0];
	endfunction

	// advance the prediction by one accepted pixel
	task automatic predict_pixel(input pixel_t p);
		longint w, h, x0, y0, x1, y1, cx, ry, dx, dy, wt, lo, hi;
		bit clip;
		frame_mean_t res;
		w = eff_dim(cfg_w);
		h = eff_dim(cfg_h);
		x0 = (r_x0 > 0) ? r_x0 : 0;
		y0 = (r_y0 > 0) ? r_y0 : 0;
		x1 = (r_x1 < (w << 8)) ? r_x1 : (w << 8);
		y1 = (r_y1 < (h << 8)) ? r_y1 : (h << 8);
		clip = (x1 > x0) && (y1 > y0);
		if (p.start) begin
			col = 0; row = 0;
			foreach (sums[c]) sums[c] = '0;
			area_acc = '0; tally = '0;
		end
		cx = col; ry = row;
		hi = ((cx + 1) << 8) < x1 ? ((cx + 1) << 8) : x1;
		lo = (cx << 8) > x0 ? (cx << 8) : x0;
		dx = hi - lo;
		hi = ((ry + 1) << 8) < y1 ? ((ry + 1) << 8) : y1;
		lo = (ry << 8) > y0 ? (ry << 8) : y0;
		dy = hi - lo;
		if (dx < 0) dx = 0;
		if (dy < 0) dy = 0;
		wt = clip ? dx * dy : 0;
		if (wt > 0) begin
			foreach (sums[c]) sums[c] += 64'(longint'(p.ch[c]) * wt);
			area_acc += 40'(wt);
			tally += 23'd1;
		end
		if (cx >= w - 1 && ry >= h - 1) begin
			res.found = clip && area_acc != 0;
			foreach (res.mean[c]) res.mean[c] = res.found ? divide_mean(sums[c], area_acc) : '0;
			res.count = tally;
			expected_means = {expected_means, res};
			col = 0; row = 0;
			foreach (sums[c]) sums[c] = '0;
			area_acc = '0; tally = '0;
		end else if (cx >= w - 1) begin
			col = 0; row = (ry + 1) & 11'h7FF;
		end else begin
			col = (cx + 1) & 11'h7FF;
		end
	endtask

	// driver: offer queued pixels, predict on each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_pixel(pending_pixels.pop_front());
			if (pending_pixels.size() != 0 && !sender_pause &&
			    ($urandom_range(99) >= idle_pct || (s_tvalid && !s_tready))) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_pixels[0].start;
				s_tdata <= {4'd0, pending_pixels[0].ch[3], pending_pixels[0].ch[2],
					pending_pixels[0].ch[1], pending_pixels[0].ch[0]};
			end else if (!(s_tvalid && !s_tready)) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		frame_mean_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_means.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = expected_means.pop_front();
					if (m_tuser !== want.found) report("found", m_tuser, want.found);
					for (int c = 0; c < 4; c++)
						if (m_tdata[25*c +: 25] !== want.mean[c])
							report($sformatf("mean[%0d]", c),
								$signed(m_tdata[25*c +: 25]), $signed(want.mean[c]));
					if (m_tdata[122:100] !== want.count)
						report("covered_count", m_tdata[122:100], want.count);
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_off <= 400;
				m_tready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_IMG_WIDTH:  cfg_w = val[11:0];
			REG_IMG_HEIGHT: cfg_h = val[11:0];
			REG_RECT_MIN_X: r_x0 = val[21:0];
			REG_RECT_MIN_Y: r_y0 = val[21:0];
			REG_RECT_MAX_X: r_x1 = val[21:0];
			default:        r_y1 = val[21:0];
		endcase
	endtask

	task automatic drain;
		while (pending_pixels.size() != 0 || s_tvalid || expected_means.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input int x0, input int y0,
			input int x1, input int y1);
		drain();
		apb_write(REG_IMG_WIDTH, w);
		apb_write(REG_IMG_HEIGHT, h);
		apb_write(REG_RECT_MIN_X, x0);
		apb_write(REG_RECT_MIN_Y, y0);
		apb_write(REG_RECT_MAX_X, x1);
		apb_write(REG_RECT_MAX_Y, y1);
	endtask

	function automatic logic signed [24:0] rand_channel();
		case ($urandom_range(5))
			0: return 25'sh0FFFFFF;
			1: return 25'sh1000000;
			2: return 25'($urandom_range(255));
			default: return 25'($urandom);
		endcase
	endfunction

	// queue one frame of npix pixels; noise sets a random start mid-frame
	task automatic queue_frame(input int npix, input bit noise);
		pixel_t p;
		for (int i = 0; i < npix; i++) begin
			p.start = (i == 0) || (noise && $urandom_range(15) == 0);
			foreach (p.ch[c]) p.ch[c] = rand_channel();
			pending_pixels = {pending_pixels, p};
		end
	endtask

	function automatic int rand_coord(input int lim);
		case ($urandom_range(4))
			0: return -$urandom_range(2000);
			1: return (lim << 8) + $urandom_range(600);
			default: return $urandom_range(lim << 8);
		endcase
	endfunction

	initial begin
		int w, h, n, npix;
		pixel_t p;
		foreach (sums[c]) sums[c] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, single pixel with empty rectangle
		p.start = 1'b1;
		foreach (p.ch[c]) p.ch[c] = 25'sh0FFFFFF;
		pending_pixels = {pending_pixels, p};
		configure(4, 3, 128, 64, 900, 700);
		p.ch[0] = 25'sh1000000; p.ch[1] = 25'sh0FFFFFF; p.ch[2] = 0; p.ch[3] = -1;
		for (int i = 0; i < 12; i++) begin
			p.start = (i == 0);
			pending_pixels = {pending_pixels, p};
		end
		// extreme rectangle registers, sizes of zero and above the maximum
		configure(0, 4095, 22'h1FFFFF, 22'h200000, 22'h1FFFFF, 22'h200000);
		queue_frame(1, 0);
		configure(3, 2, -1048576, -1048576, 1048575, 1048575);
		queue_frame(6, 0);
		configure(2, 2, 300, 10, 300, 500);
		queue_frame(4, 0);

		// long receiver hold-off while pixels keep coming
		drain();
		idle_pct = 0;
		configure(2, 1, 0, 0, 512, 256);
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++) queue_frame(2, 0);
		drain();
		idle_pct = 19;

		// random phases
		n = 0;
		while (n < 640) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 6);
			h = (w > 6) ? $urandom_range(0, 1) : $urandom_range(0, 5);
			configure(w, h, rand_coord(int'(eff_dim(w))), rand_coord(int'(eff_dim(h))),
				rand_coord(int'(eff_dim(w))), rand_coord(int'(eff_dim(h))));
			npix = int'(eff_dim(w) * eff_dim(h));
			for (int f = 0; f < 4; f++) begin
				queue_frame(npix, $urandom_range(7) == 0);
				n += npix;
			end
			if ($urandom_range(5) == 0) begin
				// sender pause until all results are in
				while (pending_pixels.size() != 0 || s_tvalid) @(posedge clk);
				sender_pause = 1'b1;
				while (expected_means.size() != 0) @(posedge clk);
				sender_pause = 1'b0;
			end
		end
		drain();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
